// ----- rtl/core/cds_pkg.sv -----
`default_nettype none

package cds_pkg;

  // Fixed sequence constants.
  localparam logic [15:0] LDR_SETTLE_TICKS = 16'd10;
  localparam logic [9:0]  GOLD_LIMIT       = 10'd800;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_MAIN_MOTOR_SPEED   = 3'd0,
    REG_PICKER_MOTOR_SPEED = 3'd1,
    REG_MAIN_STOP_DELAY    = 3'd2,
    REG_PICKER_STOP_DELAY  = 3'd3,
    REG_ALT_DEVICE_MODE    = 3'd4,
    REG_TRIGGER_PULSE_LEN  = 3'd5,
    REG_WAIT_TIMEOUT       = 3'd6,
    REG_BEAM_THRESHOLD     = 3'd7
  } cds_reg_t;

  // Reset values of the configuration registers.
  localparam logic [7:0]  RST_MAIN_MOTOR_SPEED   = 8'd255;
  localparam logic [7:0]  RST_PICKER_MOTOR_SPEED = 8'd255;
  localparam logic [15:0] RST_MAIN_STOP_DELAY    = 16'd1000;
  localparam logic [15:0] RST_PICKER_STOP_DELAY  = 16'd1500;
  localparam logic        RST_ALT_DEVICE_MODE    = 1'b0;
  localparam logic [9:0]  RST_TRIGGER_PULSE_LEN  = 10'd10;
  localparam logic [15:0] RST_WAIT_TIMEOUT       = 16'd10000;
  localparam logic [9:0]  RST_BEAM_THRESHOLD     = 10'd100;

  // Reported outcome codes.
  typedef enum logic [2:0] {
    EV_NONE          = 3'd0,
    EV_STARTED       = 3'd1,
    EV_CLEAR_TIMEOUT = 3'd2,
    EV_SUCCESS       = 3'd3,
    EV_CARD_FAULT    = 3'd4,
    EV_BLOCKED_START = 3'd5
  } cds_event_t;

  typedef struct packed {
    logic [7:0]  main_motor_speed;
    logic [7:0]  picker_motor_speed;
    logic [15:0] main_stop_delay;
    logic [15:0] picker_stop_delay;
    logic        alt_device_mode;
    logic [9:0]  trigger_pulse_len;
    logic [15:0] wait_timeout;
    logic [9:0]  beam_threshold;
  } cds_cfg_t;

  // One tick of samples; the last field sits in the lowest bits.
  typedef struct packed {
    logic       pulse_line;
    logic [9:0] ldr_level;
    logic [9:0] ir_dark_level;
    logic [9:0] ir_lit_level;
    logic       start_request;
  } cds_item_t;

  // One result per tick; the last field sits in the lowest bits.
  typedef struct packed {
    cds_event_t event_code;
    logic       gold_card;
    logic       beam_blocked;
    logic       busy_res;
    logic       ldr_lamp_on;
    logic       trigger_out;
    logic [7:0] picker_motor_duty;
    logic [7:0] main_motor_duty;
  } cds_result_t;

endpackage

`default_nettype wire

// ----- rtl/core/cds_cfg_regs.sv -----
`default_nettype none

module cds_cfg_regs
  import cds_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output cds_cfg_t         cfg
);

  cds_reg_t index;

  // The register file never stalls a write.
  assign cfg_ready = 1'b1;
  assign index     = cds_reg_t'(cfg_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.main_motor_speed   <= RST_MAIN_MOTOR_SPEED;
      cfg.picker_motor_speed <= RST_PICKER_MOTOR_SPEED;
      cfg.main_stop_delay    <= RST_MAIN_STOP_DELAY;
      cfg.picker_stop_delay  <= RST_PICKER_STOP_DELAY;
      cfg.alt_device_mode    <= RST_ALT_DEVICE_MODE;
      cfg.trigger_pulse_len  <= RST_TRIGGER_PULSE_LEN;
      cfg.wait_timeout       <= RST_WAIT_TIMEOUT;
      cfg.beam_threshold     <= RST_BEAM_THRESHOLD;
    end else if (cfg_valid && cfg_ready) begin
      case (index)
        REG_MAIN_MOTOR_SPEED:   cfg.main_motor_speed   <= cfg_data[7:0];
        REG_PICKER_MOTOR_SPEED: cfg.picker_motor_speed <= cfg_data[7:0];
        REG_MAIN_STOP_DELAY:    cfg.main_stop_delay    <= cfg_data;
        REG_PICKER_STOP_DELAY:  cfg.picker_stop_delay  <= cfg_data;
        REG_ALT_DEVICE_MODE:    cfg.alt_device_mode    <= cfg_data[0];
        REG_TRIGGER_PULSE_LEN:  cfg.trigger_pulse_len  <= cfg_data[9:0];
        REG_WAIT_TIMEOUT:       cfg.wait_timeout       <= cfg_data;
        REG_BEAM_THRESHOLD:     cfg.beam_threshold     <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/cds_seq_step.sv -----
`default_nettype none

module cds_seq_step
  import cds_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      step,
  input  wire cds_item_t item,
  input  wire cds_cfg_t  cfg,
  output cds_result_t    res
);

  typedef enum logic [8:0] {
    PH_IDLE           = 9'b000000001,
    PH_SETTLE         = 9'b000000010,
    PH_WAIT_CLEAR     = 9'b000000100,
    PH_WAIT_BLOCK     = 9'b000001000,
    PH_HOLD_PICKER    = 9'b000010000,
    PH_WAIT_CLEAR_END = 9'b000100000,
    PH_HOLD_MAIN      = 9'b001000000,
    PH_TRIGGER        = 9'b010000000,
    PH_WAIT_PULSE     = 9'b100000000
  } cds_phase_t;

  cds_phase_t  phase, phase_next;
  logic [15:0] tick_timer, tick_timer_next;
  logic        last_pulse_level, last_pulse_level_next;

  logic [15:0] inc;
  logic        timed;
  logic        blocked;
  logic [9:0]  plen;
  logic        main_on, pick_on;
  logic        trig, lamp, gold;
  cds_event_t  ev;

  assign inc     = tick_timer + 16'd1;
  assign timed   = (inc >= cfg.wait_timeout) || (inc == 16'd0);
  assign blocked = {1'b0, item.ir_dark_level} <
                   ({1'b0, item.ir_lit_level} + {1'b0, cfg.beam_threshold});
  // A pulse length of zero behaves as one tick.
  assign plen    = (cfg.trigger_pulse_len == 10'd0) ? 10'd1 : cfg.trigger_pulse_len;

  always_comb begin
    phase_next            = phase;
    tick_timer_next       = tick_timer;
    last_pulse_level_next = last_pulse_level;
    trig                  = 1'b0;
    lamp                  = 1'b0;
    gold                  = 1'b0;
    ev                    = EV_NONE;
    case (phase)
      PH_SETTLE: begin
        lamp            = 1'b1;
        tick_timer_next = inc;
        if (inc >= LDR_SETTLE_TICKS) begin
          gold            = item.ldr_level < GOLD_LIMIT;
          phase_next      = PH_WAIT_CLEAR;
          tick_timer_next = 16'd0;
        end
      end
      PH_WAIT_CLEAR: begin
        if (!blocked) begin
          phase_next      = PH_WAIT_BLOCK;
          tick_timer_next = 16'd0;
        end else begin
          tick_timer_next = inc;
          if (timed) begin
            phase_next = PH_IDLE;
            ev         = EV_CLEAR_TIMEOUT;
          end
        end
      end
      PH_WAIT_BLOCK: begin
        if (blocked) begin
          tick_timer_next = 16'd0;
          phase_next      = (cfg.picker_stop_delay == 16'd0) ? PH_WAIT_CLEAR_END
                                                              : PH_HOLD_PICKER;
        end else begin
          tick_timer_next = inc;
          if (timed) begin
            phase_next = PH_IDLE;
            ev         = EV_CARD_FAULT;
          end
        end
      end
      PH_HOLD_PICKER: begin
        tick_timer_next = inc;
        if (inc >= cfg.picker_stop_delay) begin
          phase_next      = PH_WAIT_CLEAR_END;
          tick_timer_next = 16'd0;
        end
      end
      PH_WAIT_CLEAR_END: begin
        if (!blocked) begin
          tick_timer_next = 16'd0;
          if (cfg.main_stop_delay == 16'd0) begin
            phase_next = PH_IDLE;
            ev         = EV_SUCCESS;
          end else begin
            phase_next = PH_HOLD_MAIN;
          end
        end else begin
          tick_timer_next = inc;
          if (timed) begin
            phase_next = PH_IDLE;
            ev         = EV_CARD_FAULT;
          end
        end
      end
      PH_HOLD_MAIN: begin
        tick_timer_next = inc;
        if (inc >= cfg.main_stop_delay) begin
          phase_next = PH_IDLE;
          ev         = EV_SUCCESS;
        end
      end
      PH_TRIGGER: begin
        tick_timer_next = inc;
        if (inc >= {6'd0, plen}) begin
          phase_next            = PH_WAIT_PULSE;
          tick_timer_next       = 16'd0;
          last_pulse_level_next = item.pulse_line;
        end else begin
          trig = 1'b1;
        end
      end
      PH_WAIT_PULSE: begin
        if (!last_pulse_level && item.pulse_line) begin
          phase_next = PH_IDLE;
          ev         = EV_SUCCESS;
        end else begin
          last_pulse_level_next = item.pulse_line;
          tick_timer_next       = inc;
          if (timed) begin
            phase_next = PH_IDLE;
            ev         = EV_CARD_FAULT;
          end
        end
      end
      default: begin
        // Idle, and any code that is not a phase, waits for a start.
        phase_next      = PH_IDLE;
        tick_timer_next = 16'd0;
        if (item.start_request) begin
          if (cfg.alt_device_mode) begin
            phase_next = PH_TRIGGER;
            trig       = 1'b1;
          end else if (blocked) begin
            ev = EV_BLOCKED_START;
          end else begin
            phase_next = PH_SETTLE;
            lamp       = 1'b1;
            ev         = EV_STARTED;
          end
        end
      end
    endcase
  end

  // Motor enables follow the phase that this tick leaves behind.
  assign main_on = (phase_next == PH_SETTLE) || (phase_next == PH_WAIT_CLEAR) ||
                   (phase_next == PH_WAIT_BLOCK) || (phase_next == PH_HOLD_PICKER) ||
                   (phase_next == PH_WAIT_CLEAR_END) || (phase_next == PH_HOLD_MAIN);
  assign pick_on = (phase_next == PH_SETTLE) || (phase_next == PH_WAIT_CLEAR) ||
                   (phase_next == PH_WAIT_BLOCK) || (phase_next == PH_HOLD_PICKER);

  always_comb begin
    res.main_motor_duty   = main_on ? cfg.main_motor_speed : 8'd0;
    res.picker_motor_duty = pick_on ? cfg.picker_motor_speed : 8'd0;
    res.trigger_out       = trig;
    res.ldr_lamp_on       = lamp;
    res.busy_res          = phase_next != PH_IDLE;
    res.beam_blocked      = blocked;
    res.gold_card         = gold;
    res.event_code        = ev;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      tick_timer       <= 16'd0;
      last_pulse_level <= 1'b0;
    end else if (step) begin
      phase            <= phase_next;
      tick_timer       <= tick_timer_next;
      last_pulse_level <= last_pulse_level_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/card_dispense_sequencer.sv -----
`default_nettype none

// Card dispense sequencer. Each request on the s_ stream is one millisecond
// tick of sensor samples plus a start flag, and each one produces exactly one
// result request on the m_ stream carrying the motor duties, the trigger and
// lamp levels, the busy flag, the beam and gold-card flags and an event code.
// In motor mode a start runs both motors and lights the light-sensor lamp on
// the start tick and ten settling ticks, the last of which classifies the
// card. It then follows the IR beam through clear, blocked and clear again
// with a timeout on each wait, and stops the picker and then the main motor
// after their programmed delays. In device mode a start raises the trigger
// for the programmed pulse length and then waits for a rising edge on the
// pulse line. A tick passes through an input register, then one pass of
// combinational sequencing logic updates the phase, the 16-bit tick timer and
// the last pulse level and loads the output register. The block takes one
// tick per clock cycle unless m_tready stalls; a result enters the output
// register when its tick leaves the input register, which holds it while
// the output register is full and not emptied. The only stalls come from
// m_tready. Configuration registers are written through the cfg_ port, which
// is always ready, and must only be written while no tick is in flight. Motor
// duties follow the live speed registers, while the mode is sampled at start.

module card_dispense_sequencer
  import cds_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // Sample stream.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // s_tdata, from bit 0: start_request, ir_lit_level[9:0], ir_dark_level[9:0],
  // ldr_level[9:0], pulse_line.
  input  wire logic [31:0] s_tdata,
  // Result stream.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // m_tdata, from bit 0: main_motor_duty[7:0], picker_motor_duty[7:0],
  // trigger_out, ldr_lamp_on, busy_res, beam_blocked, gold_card, event_code[2:0].
  output logic [23:0]      m_tdata,
  // Configuration write channel.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  cds_cfg_t    cfg;
  logic        in_valid;
  cds_item_t   in_item;
  logic        step;
  cds_result_t step_res;
  cds_result_t out_res;

  cds_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The held tick moves on whenever the output register is free or being
  // emptied in this cycle, and the input register refills in the same cycle.
  assign step     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item <= cds_item_t'(s_tdata);
    end
  end

  cds_seq_step u_seq_step (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (in_item),
    .cfg  (cfg),
    .res  (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= step_res;
    end
  end

  assign m_tdata = out_res;

`ifndef SYNTHESIS
  // Reset empties both the input and the output register.
  assert property (@(posedge clk) rst |=> (!m_tvalid && !in_valid))
    else $error("pipeline not empty after reset");

  // A refused start leaves the block idle with both motors stopped.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_res.event_code == EV_BLOCKED_START) |->
      (!out_res.busy_res && out_res.main_motor_duty == 8'd0 &&
       out_res.picker_motor_duty == 8'd0))
    else $error("blocked start left the sequence running");

  // The device trigger and the motors never run on the same tick.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_res.trigger_out) |->
      (out_res.main_motor_duty == 8'd0 && out_res.picker_motor_duty == 8'd0))
    else $error("trigger raised while a motor runs");

  // The card is classified only while the lamp is lit.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_res.gold_card) |-> out_res.ldr_lamp_on)
    else $error("gold card flagged with the lamp off");
`endif

endmodule

`default_nettype wire
